[hdl/kpt_pkg.sv]
// kpt_pkg: shared types and constants of the keyed parameter table
// holds the command and status codes, the transfer structs and the token passed between cells
// depends on nothing
package kpt_pkg;

   // default table geometry
   localparam int KPT_NUM_ENTRIES = 32;
   localparam int KPT_NAME_BYTES  = 16;

   // running count in the chain, wide enough for tables of up to 511 entries
   localparam int KPT_CNT_W = 9;

   // width and ceiling of the reported entry count
   localparam int KPT_COUNT_OUT_W = 6;
   localparam int KPT_COUNT_MAX   = 63;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_EXISTS = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type      cmd;
      logic [7:0]   craft_id;
      logic [7:0]   part_id;
      logic [63:0]  name_low;
      logic [63:0]  name_high;
      logic [31:0]  param_value;
      logic [7:0]   param_type;
   } req_type;

   typedef struct packed {
      logic                         found;
      status_type                   status;
      logic [KPT_COUNT_OUT_W-1:0]   entry_count;
   } rsp_type;

   // command token that walks down the chain, one cell per cycle
   typedef struct packed {
      logic                   valid;
      req_type                req;
      logic                   placed;
      logic                   found;
      logic [KPT_CNT_W-1:0]   count;
   } token_type;

endpackage

[hdl/keyed_parameter_table.sv]
// keyed_parameter_table: top level of the keyed parameter table
// builds the chain of kpt_cell entries and formats the response
// depends on kpt_pkg and kpt_cell
//
// A command is taken whenever start is high; busy stays low, since the chain
// takes one command every cycle. Each command walks down a row of NUM_ENTRIES
// cells, one cell per clock, and every cell matches and acts on its own entry
// as the command passes, so commands stay in order entry by entry. The
// response appears on rsp_data with rsp_strobe high for exactly one cycle,
// after passing the token register of every cell and then the response
// register; it cannot be held off and must be taken then.
// No clearing pass follows reset: the valid bits clear at once.
module keyed_parameter_table #(
   parameter int NUM_ENTRIES = kpt_pkg::KPT_NUM_ENTRIES,
   parameter int NAME_BYTES  = kpt_pkg::KPT_NAME_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kpt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output kpt_pkg::rsp_type rsp_data
);
   import kpt_pkg::*;

   localparam logic [KPT_COUNT_OUT_W-1:0] FullCount = (NUM_ENTRIES > KPT_COUNT_MAX) ?
      KPT_COUNT_OUT_W'(KPT_COUNT_MAX) : KPT_COUNT_OUT_W'(NUM_ENTRIES);

   token_type chain [NUM_ENTRIES+1];
   token_type last_tok;

   logic      rsp_strobe_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;

   // the chain takes a transfer every cycle
   assign busy = 1'b0;

   // token entering the first cell
   always_comb begin
      chain[0].valid  = start && !busy;
      chain[0].req    = req_data;
      chain[0].placed = 1'b0;
      chain[0].found  = 1'b0;
      chain[0].count  = '0;
   end

   // row of entry cells
   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      kpt_cell #(
         .NAME_BYTES(NAME_BYTES)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (chain[i]),
         .tok_out(chain[i+1])
      );
   end

   assign last_tok = chain[NUM_ENTRIES];

   // response formatting
   always_comb begin
      rsp_in.found = last_tok.found;
      if (last_tok.req.cmd == CMD_ADD) begin
         rsp_in.status = last_tok.placed ? STATUS_DONE : STATUS_FULL;
      end else begin
         rsp_in.status = last_tok.found ? STATUS_DONE : STATUS_NO_MATCH;
      end
      if (last_tok.count > KPT_CNT_W'(KPT_COUNT_MAX)) begin
         rsp_in.entry_count = KPT_COUNT_OUT_W'(KPT_COUNT_MAX);
      end else begin
         rsp_in.entry_count = last_tok.count[KPT_COUNT_OUT_W-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= last_tok.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a full table reports the whole table as live
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == STATUS_FULL) |-> (rsp_ff.entry_count == FullCount))
      else $error("table full reported with entries free");

   // no match means nothing was found
   a_no_match_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == STATUS_NO_MATCH) |-> !rsp_ff.found)
      else $error("no match reported together with found");

endmodule

[hdl/kpt_cell.sv]
// kpt_cell: one entry of the keyed parameter table
// matches the passing command token against its entry, acts on it and hands the token on
// depends on kpt_pkg
module kpt_cell #(
   parameter int NAME_BYTES = kpt_pkg::KPT_NAME_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  kpt_pkg::token_type tok_in,
   output kpt_pkg::token_type tok_out
);
   import kpt_pkg::*;

   localparam int NameW = NAME_BYTES * 8;

   // entry storage
   logic              valid_ff;
   logic              valid_in;
   logic [15:0]       ids_ff;
   logic [NameW-1:0]  name_ff;
   logic [31:0]       value_ff;
   logic [7:0]        type_ff;
   logic              write_key;
   logic              write_data;

   // outgoing token
   token_type         tok_ff;
   token_type         tok_in_next;

   logic [15:0]       req_ids;
   logic [NameW-1:0]  req_name;
   logic              hit;

   // names match up to the first byte that is zero in both, or over all bytes
   function automatic logic names_equal(input logic [NameW-1:0] a, input logic [NameW-1:0] b);
      logic eq;
      logic done;
      eq   = 1'b1;
      done = 1'b0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         if (!done) begin
            if (a[k*8 +: 8] != b[k*8 +: 8]) begin
               eq   = 1'b0;
               done = 1'b1;
            end else if (a[k*8 +: 8] == 8'd0) begin
               done = 1'b1;
            end
         end
      end
      return eq;
   endfunction

   assign req_ids  = {tok_in.req.craft_id, tok_in.req.part_id};
   assign req_name = NameW'({tok_in.req.name_high, tok_in.req.name_low});

   // key match against the entry as it stands before the command
   assign hit = valid_ff && (ids_ff == req_ids) && names_equal(req_name, name_ff);

   // command action on this entry
   always_comb begin
      valid_in    = valid_ff;
      write_key   = 1'b0;
      write_data  = 1'b0;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         unique case (tok_in.req.cmd)
            CMD_ADD: begin
               if (!valid_ff && !tok_in.placed) begin
                  valid_in           = 1'b1;
                  write_key          = 1'b1;
                  write_data         = 1'b1;
                  tok_in_next.placed = 1'b1;
               end
            end
            CMD_EXISTS: begin
            end
            CMD_UPDATE: begin
               write_data = hit;
            end
            CMD_REMOVE: begin
               if (hit) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
         tok_in_next.found = tok_in.found | hit;
         tok_in_next.count = tok_in.count + KPT_CNT_W'(valid_in);
      end
   end

   // valid bit and outgoing token
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.req    <= tok_in_next.req;
      tok_ff.placed <= tok_in_next.placed;
      tok_ff.found  <= tok_in_next.found;
      tok_ff.count  <= tok_in_next.count;
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (write_key) begin
         ids_ff  <= req_ids;
         name_ff <= req_name;
      end
      if (write_data) begin
         value_ff <= tok_in.req.param_value;
         type_ff  <= tok_in.req.param_type;
      end
   end

   assign tok_out = tok_ff;

   // an add already placed upstream leaves this entry alone
   a_placed_add_keeps_entry: assert property (@(posedge clock) disable iff (reset)
      (tok_in.valid && tok_in.req.cmd == CMD_ADD && tok_in.placed) |=> $stable(valid_ff))
      else $error("placed add changed a later entry");

   // a matching remove clears the entry
   a_remove_clears: assert property (@(posedge clock) disable iff (reset)
      (tok_in.valid && tok_in.req.cmd == CMD_REMOVE && hit) |=> !valid_ff)
      else $error("remove left a matching entry valid");

   // only an add can carry the placed mark
   a_placed_only_add: assert property (@(posedge clock) disable iff (reset)
      (tok_ff.valid && tok_ff.placed) |-> (tok_ff.req.cmd == CMD_ADD))
      else $error("placed mark on a command other than add");

endmodule

[tb/kpt_table_checker.sv]
// kpt_table_checker: response checker for the keyed parameter table
// predicts each response from accepted commands and compares it field by field
// depends on kpt_pkg
`timescale 1ns / 100ps

module kpt_table_checker #(
   parameter int NUM_ENTRIES = kpt_pkg::KPT_NUM_ENTRIES,
   parameter int NAME_BYTES  = kpt_pkg::KPT_NAME_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  kpt_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  kpt_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count
);
   import kpt_pkg::*;

   // predicted table contents
   logic         live         [NUM_ENTRIES];
   logic [15:0]  key_ids      [NUM_ENTRIES];
   logic [127:0] key_name     [NUM_ENTRIES];
   logic [31:0]  stored_value [NUM_ENTRIES];
   logic [7:0]   stored_type  [NUM_ENTRIES];

   // responses still owed by the block, oldest first
   rsp_type pending_responses[$];
   int      mismatches  = 0;
   int      outstanding = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = outstanding;

   // byte-wise name compare, equal at the first zero byte common to both
   function automatic logic names_match(logic [127:0] a, logic [127:0] b);
      for (int k = 0; k < NAME_BYTES && k < 16; k++) begin
         if (a[8*k +: 8] != b[8*k +: 8]) return 1'b0;
         if (a[8*k +: 8] == 8'h00) return 1'b1;
      end
      return 1'b1;
   endfunction

   // run one command on the predicted table and return its response
   function automatic rsp_type apply_table_command(req_type r);
      logic [15:0]  ids;
      logic [127:0] name;
      logic         hit [NUM_ENTRIES];
      logic         any_hit;
      logic         placed;
      int           live_total;
      rsp_type      rsp;
      ids     = {r.craft_id, r.part_id};
      name    = {r.name_high, r.name_low};
      any_hit = 1'b0;
      placed  = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         hit[i] = live[i] && (key_ids[i] == ids) && names_match(name, key_name[i]);
         if (hit[i]) any_hit = 1'b1;
      end
      if (r.cmd == CMD_ADD) begin
         // lowest free entry takes the key, bytes past NAME_BYTES stored as zero
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!placed && !live[i]) begin
               live[i]     = 1'b1;
               key_ids[i]  = ids;
               key_name[i] = name;
               for (int k = NAME_BYTES; k < 16; k++) key_name[i][8*k +: 8] = 8'h00;
               stored_value[i] = r.param_value;
               stored_type[i]  = r.param_type;
               placed = 1'b1;
            end
         end
         rsp.status = placed ? STATUS_DONE : STATUS_FULL;
      end else begin
         // exists, update and remove act on every matching entry
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (hit[i] && r.cmd == CMD_UPDATE) begin
               stored_value[i] = r.param_value;
               stored_type[i]  = r.param_type;
            end
            if (hit[i] && r.cmd == CMD_REMOVE) live[i] = 1'b0;
         end
         rsp.status = any_hit ? STATUS_DONE : STATUS_NO_MATCH;
      end
      live_total = 0;
      for (int i = 0; i < NUM_ENTRIES; i++) if (live[i]) live_total++;
      rsp.found = any_hit;
      if (live_total > KPT_COUNT_MAX) rsp.entry_count = KPT_COUNT_OUT_W'(KPT_COUNT_MAX);
      else rsp.entry_count = KPT_COUNT_OUT_W'(live_total);
      return rsp;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // response check first, then the command transfer of the same edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) live[i] = 1'b0;
         pending_responses.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("unexpected response, count", 8'(rsp_data.entry_count), 8'h0);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 8'(rsp_data.found), 8'(want.found));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 8'(rsp_data.status), 8'(want.status));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 8'(rsp_data.entry_count),
                                  8'(want.entry_count));
            end
         end
         if (start && !busy) pending_responses.push_back(apply_table_command(req_data));
      end
      outstanding = pending_responses.size();
   end

endmodule

[tb/keyed_parameter_table_tb.sv]
// keyed_parameter_table_tb: stimulus and verdict for the keyed parameter table
// drives directed and random command bursts, checking is done by kpt_table_checker
// depends on kpt_pkg, keyed_parameter_table and kpt_table_checker
`timescale 1ns / 100ps

module keyed_parameter_table_tb;
   import kpt_pkg::*;

   localparam int NUM_ENTRIES = KPT_NUM_ENTRIES;
   localparam int NAME_BYTES  = KPT_NAME_BYTES;
   localparam int KEY_POOL    = 48;

   // directed names
   localparam logic [127:0] NAME_EMPTY = '0;
   localparam logic [127:0] NAME_FULL  = {16{8'hFF}};
   localparam logic [127:0] NAME_FULL_TAIL = {8'hFE, {15{8'hFF}}};
   localparam logic [127:0] NAME_A_JUNK1 = {{14{8'hAA}}, 8'h00, 8'h41};
   localparam logic [127:0] NAME_A_JUNK2 = {{14{8'h5A}}, 8'h00, 8'h41};
   localparam logic [127:0] NAME_AB = {{14{8'h00}}, 8'h42, 8'h41};

   typedef struct packed {
      logic [7:0]   craft_id;
      logic [7:0]   part_id;
      logic [127:0] name;
   } table_key_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_strobe;
   req_type req_data;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pending_count;

   // keys added so far, reused for lookups and duplicate adds
   table_key_type known_keys[$];

   keyed_parameter_table #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   kpt_table_checker #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) table_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // empty, unterminated or short names, sometimes with junk past the terminator
   function automatic logic [127:0] random_name();
      logic [127:0] n;
      int           len;
      bit           junk;
      n = '0;
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = 16;
         default: len = $urandom_range(1, 15);
      endcase
      junk = 1'($urandom_range(0, 1));
      for (int k = 0; k < 16; k++) begin
         if (k < len) n[8*k +: 8] = 8'($urandom_range(1, 255));
         else if (k > len && junk) n[8*k +: 8] = 8'($urandom);
      end
      return n;
   endfunction

   function automatic table_key_type fresh_key();
      table_key_type k;
      k.craft_id = 8'($urandom);
      k.part_id  = 8'($urandom);
      k.name     = random_name();
      return k;
   endfunction

   // mostly known keys, some exact, some with changed junk, some near misses
   function automatic table_key_type lookup_key();
      table_key_type k;
      int            term;
      int            pos;
      if (known_keys.size() == 0 || $urandom_range(0, 4) == 0) return fresh_key();
      k    = known_keys[$urandom_range(0, known_keys.size() - 1)];
      term = 16;
      for (int b = 15; b >= 0; b--) if (k.name[8*b +: 8] == 8'h00) term = b;
      pos = $urandom_range(0, 15);
      case ($urandom_range(0, 5))
         0: for (int b = term + 1; b < 16; b++) k.name[8*b +: 8] = 8'($urandom);
         1: k.name[8*pos +: 8] = k.name[8*pos +: 8] ^ 8'($urandom_range(1, 255));
         2: k.craft_id = k.craft_id ^ 8'(1 << $urandom_range(0, 7));
         3: k.part_id = k.part_id ^ 8'(1 << $urandom_range(0, 7));
         default: ;
      endcase
      return k;
   endfunction

   // one command transfer, start stays high until the next change
   task automatic send_command(cmd_type cmd, table_key_type k, logic [31:0] value,
                               logic [7:0] ptype);
      req_type r;
      r.cmd          = cmd;
      r.craft_id     = k.craft_id;
      r.part_id      = k.part_id;
      r.name_low     = k.name[63:0];
      r.name_high    = k.name[127:64];
      r.param_value  = value;
      r.param_type   = ptype;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (cmd == CMD_ADD) begin
         if (known_keys.size() < KEY_POOL) known_keys.push_back(k);
         else known_keys[$urandom_range(0, KEY_POOL - 1)] = k;
      end
   endtask

   task automatic pause_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // hold off until every response owed has come back
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      wait (pending_count == 0);
   endtask

   // random bursts with a given command mix
   task automatic run_random(int items, int add_w, int exists_w, int update_w,
                             int remove_w);
      int            sent;
      int            burst;
      int            pick;
      cmd_type       cmd;
      table_key_type k;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && sent < items; b++) begin
            pick = $urandom_range(0, add_w + exists_w + update_w + remove_w - 1);
            if (pick < add_w) cmd = CMD_ADD;
            else if (pick < add_w + exists_w) cmd = CMD_EXISTS;
            else if (pick < add_w + exists_w + update_w) cmd = CMD_UPDATE;
            else cmd = CMD_REMOVE;
            if (cmd == CMD_ADD && $urandom_range(0, 3) != 0) k = fresh_key();
            else k = lookup_key();
            send_command(cmd, k, $urandom, 8'($urandom));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 40));
      end
   endtask

   initial begin
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: nothing matches
      send_command(CMD_EXISTS, {8'h00, 8'h00, NAME_EMPTY}, 32'h0, 8'h00);
      send_command(CMD_UPDATE, {8'h00, 8'h00, NAME_EMPTY}, 32'h0, 8'h00);
      send_command(CMD_REMOVE, {8'h00, 8'h00, NAME_EMPTY}, 32'h0, 8'h00);
      // extreme keys and data
      send_command(CMD_ADD, {8'h00, 8'h00, NAME_EMPTY}, 32'h0, 8'h00);
      send_command(CMD_ADD, {8'hFF, 8'hFF, NAME_FULL}, 32'hFFFF_FFFF, 8'hFF);
      send_command(CMD_EXISTS, {8'h00, 8'h00, NAME_EMPTY}, 32'h0, 8'h00);
      send_command(CMD_EXISTS, {8'hFF, 8'hFF, NAME_FULL}, 32'h0, 8'h00);
      // unterminated name differing only in the last byte
      send_command(CMD_EXISTS, {8'hFF, 8'hFF, NAME_FULL_TAIL}, 32'h0, 8'h00);
      send_command(CMD_EXISTS, {8'hFE, 8'hFF, NAME_FULL}, 32'h0, 8'h00);
      // compare stops at the terminator
      send_command(CMD_ADD, {8'h12, 8'h34, NAME_A_JUNK1}, 32'h1, 8'h01);
      send_command(CMD_EXISTS, {8'h12, 8'h34, NAME_A_JUNK2}, 32'h0, 8'h00);
      send_command(CMD_EXISTS, {8'h12, 8'h34, NAME_AB}, 32'h0, 8'h00);
      // duplicate key, then update and remove hit both copies
      send_command(CMD_ADD, {8'h12, 8'h34, NAME_A_JUNK2}, 32'h2, 8'h02);
      send_command(CMD_UPDATE, {8'h12, 8'h34, NAME_A_JUNK1}, 32'hA5A5_5A5A, 8'h5A);
      send_command(CMD_REMOVE, {8'h12, 8'h34, NAME_A_JUNK2}, 32'h0, 8'h00);
      send_command(CMD_EXISTS, {8'h12, 8'h34, NAME_A_JUNK1}, 32'h0, 8'h00);
      send_command(CMD_UPDATE, {8'hFF, 8'hFF, NAME_FULL}, 32'h0, 8'h00);
      send_command(CMD_REMOVE, {8'h00, 8'h00, NAME_EMPTY}, 32'h0, 8'h00);
      send_command(CMD_REMOVE, {8'hFF, 8'hFF, NAME_FULL}, 32'h0, 8'h00);
      send_command(CMD_EXISTS, {8'hFF, 8'hFF, NAME_FULL}, 32'h0, 8'h00);
      wait_for_drain();

      // fill past full, churn, drain down, refill
      run_random(200, 6, 2, 1, 1);
      wait_for_drain();
      run_random(300, 3, 3, 2, 2);
      wait_for_drain();
      run_random(150, 1, 2, 1, 6);
      wait_for_drain();
      run_random(250, 4, 2, 2, 2);

      // let any stray response show up before the verdict
      wait_for_drain();
      repeat (NUM_ENTRIES + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/kpt_pkg.sv
hdl/kpt_cell.sv
hdl/keyed_parameter_table.sv
tb/kpt_table_checker.sv
tb/keyed_parameter_table_tb.sv
